FILE: design/lst_pkg.sv
// Shared types, constants and the remainder step function for the LWE
// secret-reduction transform. No dependencies.
package lst_pkg;

  localparam int W           = 15;   // modulus / coefficient width
  localparam int POS_W       = 10;   // position field width
  localparam int SEC_W       = 8;    // stored secret entry width
  localparam int MAX_DIM_DEF = 1024;
  localparam int RED_BITS    = 3;    // quotient bits resolved per pipeline stage
  localparam int RED_STAGES  = W / RED_BITS;
  localparam int CNT_W       = $clog2(W);

  localparam logic [W-1:0] Q_MIN  = W'(2);
  localparam logic [W-1:0] Q_RST  = W'(2);

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    WT_ZERO,
    WT_ONE,
    WT_NEG
  } wt_t;

  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] rhs;
    logic         last;
    wt_t          wt;
  } item_t;

  // Three steps of restoring remainder: subtract q<<k for k = hi, hi-1, hi-2.
  function automatic logic [W-1:0] rem_step(input logic [W-1:0] rem,
                                            input logic [W-1:0] q,
                                            input int           hi);
    logic [2*W-1:0] r;
    logic [2*W-1:0] d;
    r = (2*W)'(rem);
    for (int j = 0; j < RED_BITS; j++) begin
      if (hi - j >= 0) begin
        d = (2*W)'(q) << (hi - j);
        if (r >= d) begin
          r = r - d;
        end
      end
    end
    return r[W-1:0];
  endfunction

endpackage

FILE: design/lst_in_if.sv
// Input word channel: valid/ready plus one load or sample word.
// Depends on lst_pkg.
interface lst_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lst_pkg::POS_W-1:0] position;
  logic [lst_pkg::W-1:0]     value;
  logic [lst_pkg::W-1:0]     rhs;
  logic                      final_req;

  modport source (output valid, action, position, value, rhs, final_req, input ready);
  modport sink   (input valid, action, position, value, rhs, final_req, output ready);
endinterface

FILE: design/lst_out_if.sv
// Result word channel: valid/ready plus one result word.
// Depends on lst_pkg.
interface lst_out_if;
  logic                  valid;
  logic                  ready;
  logic [lst_pkg::W-1:0] doubled_coef;
  logic [lst_pkg::W-1:0] new_rhs;
  logic                  done_res;

  modport source (output valid, doubled_coef, new_rhs, done_res, input ready);
  modport sink   (input valid, doubled_coef, new_rhs, done_res, output ready);
endinterface

FILE: design/lwe_sample_secret_lsb_transform_top.sv
// LWE sample transform: load words store secret low bits, sample words
// stream coefficients a and give (2a mod q) each, plus (b - sum) mod q on the
// last coefficient. One word is accepted per cycle, loads and samples alike,
// while the pipeline is not stalled and no re-reduction runs; a sample passes
// the input/memory-read register, five remainder stages of three quotient bits
// each, the sign-term stage and the result register, and the pipeline keeps
// accepting while a result waits as long as a stage is free. A modulus write
// re-reduces the accumulator bit by bit, holding in_ch.ready low while it runs.
// The secret store is a MAX_DIM x 8 memory with no reset.
// Depends on lst_pkg, lst_in_if, lst_out_if, lst_secret_mem, lst_mod_pipe, lst_tail.
module lwe_sample_secret_lsb_transform_top #(
  parameter int MAX_DIM = lst_pkg::MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lst_in_if.sink                in_ch,
  lst_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [lst_pkg::W-1:0] cfg_wr_data
);

  localparam int W  = lst_pkg::W;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [W-1:0] q_r;

  logic [31:0]   pos_w;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          in_fire, is_sample;

  logic         s0_v_r;
  logic [W-1:0] s0_a_r, s0_rhs_r;
  logic         s0_last_r, s0_range_r;
  logic [lst_pkg::SEC_W-1:0] sec;
  lst_pkg::wt_t s0_wt;
  lst_pkg::item_t s0_item;

  logic           mp_ready, mp_out_valid, tail_ready, busy;
  lst_pkg::item_t mp_out_item;
  logic           s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= lst_pkg::Q_RST;
    end else if (cfg_wr_en) begin
      q_r <= (cfg_wr_data < lst_pkg::Q_MIN) ? lst_pkg::Q_MIN : cfg_wr_data;
    end
  end

  assign pos_w     = 32'(in_ch.position);
  assign addr      = pos_w[AW-1:0];
  assign in_range  = pos_w < 32'(MAX_DIM);
  assign s0_rdy    = !s0_v_r || mp_ready;
  assign in_ch.ready = s0_rdy && !busy;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign is_sample = in_ch.action == lst_pkg::ACTION_SAMPLE;

  lst_secret_mem #(.MAX_DIM(MAX_DIM), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (in_fire && !is_sample && in_range),
    .wr_addr (addr),
    .wr_data (in_ch.value[lst_pkg::SEC_W-1:0]),
    .rd_en   (in_fire && is_sample),
    .rd_addr (addr),
    .rd_data (sec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_fire && is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_sample) begin
      s0_a_r     <= in_ch.value;
      s0_rhs_r   <= in_ch.rhs;
      s0_last_r  <= in_ch.final_req;
      s0_range_r <= in_range;
    end
  end

  // weight from the secret entry: zero for a zero or out-of-range entry, +1 up to floor(q/2), else q-1
  always_comb begin
    if (!s0_range_r || sec == '0) begin
      s0_wt = lst_pkg::WT_ZERO;
    end else if (W'(sec) <= (q_r >> 1)) begin
      s0_wt = lst_pkg::WT_ONE;
    end else begin
      s0_wt = lst_pkg::WT_NEG;
    end
    s0_item.a    = s0_a_r;
    s0_item.rhs  = s0_rhs_r;
    s0_item.last = s0_last_r;
    s0_item.wt   = s0_wt;
  end

  lst_mod_pipe u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q_r),
    .in_valid  (s0_v_r),
    .in_ready  (mp_ready),
    .in_item   (s0_item),
    .out_valid (mp_out_valid),
    .out_ready (tail_ready),
    .out_item  (mp_out_item)
  );

  lst_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .q        (q_r),
    .cfg_wr   (cfg_wr_en),
    .busy     (busy),
    .in_valid (mp_out_valid),
    .in_ready (tail_ready),
    .in_item  (mp_out_item),
    .out_ch   (out_ch)
  );

endmodule

FILE: design/lst_secret_mem.sv
// Secret low-bit store: one write port, one registered read port.
// Depends on lst_pkg.
module lst_secret_mem #(
  parameter int MAX_DIM = lst_pkg::MAX_DIM_DEF,
  parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lst_pkg::SEC_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lst_pkg::SEC_W-1:0] rd_data
);

  logic [lst_pkg::SEC_W-1:0] mem [MAX_DIM];
  logic [lst_pkg::SEC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/lst_mod_pipe.sv
// Pipelined remainder unit: reduces coefficient and rhs mod q, three
// quotient bits per stage, with bubble-collapsing flow control.
// Depends on lst_pkg.
module lst_mod_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [lst_pkg::W-1:0] q,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lst_pkg::item_t        in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lst_pkg::item_t        out_item
);

  localparam int N = lst_pkg::RED_STAGES;

  logic           v_r    [N];
  lst_pkg::item_t item_r [N];
  logic           rdy    [N+1];

  always_comb begin
    rdy[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int HI = lst_pkg::W - 1 - g * lst_pkg::RED_BITS;

    logic           up_v;
    lst_pkg::item_t up_item;
    lst_pkg::item_t item_nxt;

    if (g == 0) begin : g_first
      assign up_v    = in_valid;
      assign up_item = in_item;
    end else begin : g_rest
      assign up_v    = v_r[g-1];
      assign up_item = item_r[g-1];
    end

    always_comb begin
      item_nxt     = up_item;
      item_nxt.a   = lst_pkg::rem_step(up_item.a, q, HI);
      item_nxt.rhs = lst_pkg::rem_step(up_item.rhs, q, HI);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= up_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && up_v) begin
        item_r[g] <= item_nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_item  = item_r[N-1];

endmodule

FILE: design/lst_tail.sv
// Sign-term stage, dot accumulator and result register. Also re-reduces
// the accumulator after a modulus write. Depends on lst_pkg, lst_out_if.
module lst_tail (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [lst_pkg::W-1:0] q,
  input  logic                  cfg_wr,
  output logic                  busy,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lst_pkg::item_t        in_item,
  lst_out_if.source             out_ch
);

  localparam int W  = lst_pkg::W;
  localparam int CW = lst_pkg::CNT_W;

  // prep stage
  logic         p_v_r;
  logic [W-1:0] p_dbl_r, p_term_r, p_rhs_r;
  logic         p_last_r;
  logic [W:0]   dbl2;
  logic [W-1:0] dbl_nxt, term_nxt;

  // output stage
  logic         o_v_r;
  logic [W-1:0] o_dbl_r, o_rhs_r;
  logic         o_done_r;
  logic [W:0]   sum;
  logic [W-1:0] sum_red;
  logic [W:0]   nrhs_full;
  logic [W-1:0] nrhs;

  logic [W-1:0]   acc_r, acc_nxt;
  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [2*W-1:0] red_d;

  logic o_rdy, p_rdy, p_move;

  assign o_rdy  = !o_v_r || out_ch.ready;
  assign p_rdy  = !p_v_r || o_rdy;
  assign p_move = p_v_r && o_rdy;
  assign in_ready = p_rdy;

  always_comb begin
    dbl2    = {in_item.a, 1'b0};
    dbl_nxt = (dbl2 >= (W+1)'(q)) ? W'(dbl2 - (W+1)'(q)) : W'(dbl2);
    case (in_item.wt)
      lst_pkg::WT_ONE: term_nxt = in_item.a;
      lst_pkg::WT_NEG: term_nxt = (in_item.a == '0) ? '0 : q - in_item.a;
      default:         term_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_rdy) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy && in_valid) begin
      p_dbl_r  <= dbl_nxt;
      p_term_r <= term_nxt;
      p_rhs_r  <= in_item.rhs;
      p_last_r <= in_item.last;
    end
  end

  always_comb begin
    sum       = (W+1)'(acc_r) + (W+1)'(p_term_r);
    sum_red   = (sum >= (W+1)'(q)) ? W'(sum - (W+1)'(q)) : W'(sum);
    nrhs_full = (p_rhs_r >= sum_red) ? (W+1)'(p_rhs_r - sum_red)
                                     : (W+1)'(p_rhs_r) + (W+1)'(q) - (W+1)'(sum_red);
    nrhs      = nrhs_full[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_dbl_r  <= p_dbl_r;
      o_rhs_r  <= p_last_r ? nrhs : '0;
      o_done_r <= p_last_r;
    end
  end

  // after a modulus change: one restoring step per cycle, top shift first
  assign red_d = (2*W)'(q) << cnt_r;

  always_comb begin
    acc_nxt = acc_r;
    if (busy_r) begin
      if ((2*W)'(acc_r) >= red_d) begin
        acc_nxt = acc_r - red_d[W-1:0];
      end
    end else if (p_move) begin
      acc_nxt = p_last_r ? '0 : sum_red;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (cfg_wr) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;

  assign out_ch.valid        = o_v_r;
  assign out_ch.doubled_coef = o_dbl_r;
  assign out_ch.new_rhs      = o_rhs_r;
  assign out_ch.done_res     = o_done_r;

endmodule
